@@ rtl/uts_pkg.sv @@
// ============================================================================
// uts_pkg
// Shared types, constants and character-class functions for the
// request-target span parser.
// ============================================================================
package uts_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int OUT_BITS    = 16;
    localparam int SPAN_COUNT  = 3;

    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_RESTART = 1'b1;

    localparam logic [1:0] SEC_PATH  = 2'd0;
    localparam logic [1:0] SEC_QUERY = 2'd1;
    localparam logic [1:0] SEC_FRAG  = 2'd2;
    localparam logic [1:0] SEC_PCT   = 2'd3;

    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_SLASH    = 8'h2F;

    localparam int RESULT_BITS = 2 + 2 + 7 * OUT_BITS;
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] fragment_len;
        logic [OUT_BITS-1:0] fragment_start;
        logic [OUT_BITS-1:0] query_len;
        logic [OUT_BITS-1:0] query_start;
        logic [OUT_BITS-1:0] path_len;
        logic [OUT_BITS-1:0] path_start;
        logic [OUT_BITS-1:0] offset;
        logic [1:0]          section;
        logic [1:0]          status;
    } result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_plain(input logic [7:0] c);
        logic alnum;
        logic mark;
        alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h41 && c <= 8'h5A);
        mark  = c == 8'h2D || c == 8'h2E || c == 8'h5F || c == CH_TILDE ||
                c == 8'h21 || c == 8'h24 || (c >= 8'h26 && c <= 8'h2C) ||
                c == 8'h3B || c == 8'h3D || c == 8'h3A || c == CH_AT ||
                c == CH_SLASH || c == CH_QUESTION;
        return alnum || mark;
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(input offset_t v);
        return OUT_BITS'(v);
    endfunction

endpackage

@@ rtl/uts_in_reg.sv @@
// ============================================================================
// uts_in_reg
// Input register: captures one beat from the slave side and holds it until
// the parse core takes it.
// ============================================================================
module uts_in_reg
    import uts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ rtl/uts_parse_core.sv @@
// ============================================================================
// uts_parse_core
// Parser state and per-byte update: character-class check, section moves,
// percent-escape tracking and span bookkeeping.
// ============================================================================
module uts_parse_core
    import uts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   start_offset,
    input  logic          take,
    input  item_t         item,
    output result_t       result
);

    logic [2:0] section_reg;
    logic [2:0] section_next;
    logic [1:0] esc_ret_reg;
    logic [1:0] esc_ret_next;
    logic [1:0] hex_reg;
    logic [1:0] hex_next;
    logic       done_reg;
    logic       done_next;
    offset_t    cursor_reg;
    offset_t    cursor_next;
    offset_t    starts_reg [SPAN_COUNT];
    offset_t    starts_next [SPAN_COUNT];
    offset_t    lens_reg [SPAN_COUNT];
    offset_t    lens_next [SPAN_COUNT];

    always_comb
    begin
        logic [7:0] c;
        logic [1:0] sec;
        offset_t    base;
        offset_t    step;
        c    = item.byte_value;
        sec  = section_reg[1:0];
        base = offset_t'(start_offset);
        step = cursor_reg + offset_t'(1);

        section_next = section_reg;
        esc_ret_next = esc_ret_reg;
        hex_next     = hex_reg;
        done_next    = done_reg;
        cursor_next  = cursor_reg;
        starts_next  = starts_reg;
        lens_next    = lens_reg;

        if (item.kind == KIND_RESTART)
        begin
            section_next   = {1'b0, SEC_PATH};
            esc_ret_next   = SEC_PATH;
            hex_next       = 2'd0;
            done_next      = 1'b0;
            cursor_next    = base;
            starts_next[0] = base;
            starts_next[1] = '0;
            starts_next[2] = '0;
            lens_next[0]   = '0;
            lens_next[1]   = '0;
            lens_next[2]   = '0;
        end
        else if (!done_reg && !section_reg[2])
        begin
            if (sec == SEC_PCT)
            begin
                if (!is_hex(c))
                begin
                    section_next = {1'b1, SEC_PCT};
                end
                else
                begin
                    hex_next    = hex_reg + 2'd1;
                    cursor_next = step;
                    if (hex_reg + 2'd1 >= 2'd2)
                    begin
                        section_next = {1'b0, esc_ret_reg};
                    end
                end
            end
            else if (c == CH_QUESTION && sec == SEC_PATH)
            begin
                lens_next[0]   = cursor_reg - starts_reg[0];
                cursor_next    = step;
                starts_next[1] = step;
                lens_next[1]   = '0;
                section_next   = {1'b0, SEC_QUERY};
            end
            else if (c == CH_HASH && sec != SEC_FRAG)
            begin
                lens_next[sec] = cursor_reg - starts_reg[sec];
                cursor_next    = step;
                starts_next[2] = step;
                lens_next[2]   = '0;
                section_next   = {1'b0, SEC_FRAG};
            end
            else if (c == CH_PERCENT)
            begin
                esc_ret_next = sec;
                hex_next     = 2'd0;
                cursor_next  = step;
                section_next = {1'b0, SEC_PCT};
            end
            else if (is_ws(c))
            begin
                lens_next[sec] = cursor_reg - starts_reg[sec];
                done_next      = 1'b1;
            end
            else if (is_plain(c))
            begin
                cursor_next = step;
            end
            else
            begin
                section_next = {1'b1, sec};
            end
        end
    end

    always_comb
    begin
        if (section_next[2])
        begin
            result.status = ST_ERROR;
        end
        else if (done_next)
        begin
            result.status = ST_COMPLETE;
        end
        else
        begin
            result.status = ST_RUNNING;
        end
        result.section        = section_next[1:0];
        result.offset         = to_out(cursor_next);
        result.path_start     = to_out(starts_next[0]);
        result.path_len       = to_out(lens_next[0]);
        result.query_start    = to_out(starts_next[1]);
        result.query_len      = to_out(lens_next[1]);
        result.fragment_start = to_out(starts_next[2]);
        result.fragment_len   = to_out(lens_next[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg <= {1'b0, SEC_PATH};
            esc_ret_reg <= SEC_PATH;
            hex_reg     <= 2'd0;
            done_reg    <= 1'b0;
            cursor_reg  <= '0;
            starts_reg  <= '{default: '0};
            lens_reg    <= '{default: '0};
        end
        else if (take)
        begin
            section_reg <= section_next;
            esc_ret_reg <= esc_ret_next;
            hex_reg     <= hex_next;
            done_reg    <= done_next;
            cursor_reg  <= cursor_next;
            starts_reg  <= starts_next;
            lens_reg    <= lens_next;
        end
    end

endmodule

@@ rtl/uts_out_reg.sv @@
// ============================================================================
// uts_out_reg
// Result register: holds one result beat for the master side and frees
// itself as the beat is taken.
// ============================================================================
module uts_out_reg
    import uts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  result_t               result,
    output logic                  load_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TDATA_BITS-1:0] out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = TDATA_BITS'(result_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ rtl/uri_target_span_parser_unit.sv @@
// ============================================================================
// uri_target_span_parser_unit
// Streaming parser for the path, query and fragment spans of a request target.
// ============================================================================
// One input beat gives one result beat. A beat passes an input register, a
// combinational class check and state update, and a result register; a new
// beat is accepted every cycle while the master side keeps taking results.
// start_offset takes effect at the next restart beat; reset clears it to zero.
module uri_target_span_parser_unit
    import uts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,      // start_offset
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // byte_value
    input  logic                  s_axis_tuser,   // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, section, offset, path_start, path_len, query_start,
    // query_len, fragment_start, fragment_len, zero pad
    output logic [TDATA_BITS-1:0] m_axis_tdata
);

    logic [15:0] start_offset_reg;
    item_t       in_item;
    item_t       item;
    logic        item_valid;
    logic        load_ready;
    logic        take;
    result_t     result;

    assign in_item.kind       = s_axis_tuser;
    assign in_item.byte_value = s_axis_tdata;
    assign take               = item_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_offset_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            start_offset_reg <= cfg_wdata;
        end
    end

    uts_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (take)
    );

    uts_parse_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_offset (start_offset_reg),
        .take         (take),
        .item         (item),
        .result       (result)
    );

    uts_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .result     (result),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule
